@@ design/spq_pkg.sv @@
// shared types, codes and the ordering rule of the priority queue
`timescale 1ns / 1ps
`default_nettype none
package spq_pkg;

   localparam int CAPACITY_DEFAULT = 16;
   localparam int SCORE_WIDTH      = 16;
   localparam int ARRIVAL_WIDTH    = 16;
   localparam int COUNT_OUT_WIDTH  = 5;

   localparam logic FUNC_INSERT = 1'b0;
   localparam logic FUNC_REMOVE = 1'b1;

   typedef struct packed {
      logic [SCORE_WIDTH-1:0]   score;
      logic [ARRIVAL_WIDTH-1:0] arrival;
   } entry_type;

   // operation broadcast to every cell, already checked against full and empty
   typedef struct packed {
      logic      insert;
      logic      remove;
      entry_type entry;
   } cmd_type;

   // true when entry a is served before entry b
   function automatic logic goes_before(input entry_type a, input entry_type b);
      logic result;
      if (a.score != b.score) begin
         result = (a.score > b.score);
      end else begin
         result = (a.arrival < b.arrival);
      end
      return result;
   endfunction

endpackage
`default_nettype wire

@@ design/spq_cell.sv @@
// one slot of the sorted queue: holds an entry, shifts left on remove, right on insert
`timescale 1ns / 1ps
`default_nettype none
module spq_cell #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT,
   parameter int INDEX    = 0
) (
   input  wire                             clock,
   input  spq_pkg::cmd_type                cmd,
   input  wire [$clog2(CAPACITY+1)-1:0]    count,
   input  spq_pkg::entry_type              left_entry,
   input  wire                             left_shift,
   input  spq_pkg::entry_type              right_entry,
   output spq_pkg::entry_type              entry,
   output logic                            shift_out
);

   localparam int CountWidth = $clog2(CAPACITY+1);

   spq_pkg::entry_type entry_ff;
   spq_pkg::entry_type entry_in;
   logic               occupied;
   logic               at_tail;
   logic               new_first;

   assign occupied  = (count > CountWidth'(INDEX));
   assign at_tail   = (count == CountWidth'(INDEX));
   assign new_first = spq_pkg::goes_before(cmd.entry, entry_ff);
   // this cell's entry moves one place toward the tail when an insert goes before it
   assign shift_out = occupied && new_first;

   always_comb begin
      entry_in = entry_ff;
      priority if (cmd.remove) begin
         entry_in = right_entry;
      end else if (cmd.insert) begin
         priority if (left_shift) begin
            entry_in = left_entry;
         end else if (shift_out || at_tail) begin
            entry_in = cmd.entry;
         end
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule
`default_nettype wire

@@ design/sorted_priority_queue.sv @@
// Bounded priority queue kept sorted in a row of shifting cells.
// The req_ channel carries one operation per item: tuser selects insert (0) or
// remove of the head (1); tdata holds the score and arrival of an entry to insert.
// The head is the highest score, ties go to the earlier arrival, then to the
// earlier insert. Every accepted item yields exactly one rsp_ item with the
// removed entry (zeros otherwise), an entry flag, an error flag for insert on
// full or remove on empty, the count after the operation and empty/full flags.
// All cells compare against the new entry in parallel and shift in the same
// clock, so an operation finishes in the cycle it is accepted; its result sits
// in the output register and appears in the cycle after acceptance.
// Throughput is one item per cycle while results are taken (single output register).
// When the receiver stalls with a result held, req_tready drops until the result
// is taken. Reset empties the queue at once; no clearing pass is needed because
// only slots below the count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module sorted_priority_queue #(
   parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // in_score[15:0], in_arrival[31:16]
   input  wire         req_tuser,   // func[0]
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [47:0] rsp_tdata    // out_score[15:0], out_arrival[31:16], out_valid[32],
                                    // op_error[33], entry_count[38:34], is_empty[39],
                                    // is_full[40], zero[47:41]
);

   localparam int CountWidth = $clog2(CAPACITY+1);

   logic [CountWidth-1:0] count_ff;
   logic [CountWidth-1:0] count_in;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [47:0]           rsp_data_ff;
   logic [47:0]           rsp_data_in;

   spq_pkg::entry_type    cells [CAPACITY];
   logic                  shifts [CAPACITY];
   spq_pkg::cmd_type      cmd;
   spq_pkg::entry_type    req_entry;
   spq_pkg::entry_type    head;
   logic                  accept;
   logic                  is_empty_now;
   logic                  is_full_now;
   logic                  refused;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   assign req_entry.score   = req_tdata[15:0];
   assign req_entry.arrival = req_tdata[31:16];

   assign is_empty_now = (count_ff == '0);
   assign is_full_now  = (count_ff == CountWidth'(CAPACITY));

   always_comb begin
      cmd.entry  = req_entry;
      cmd.insert = accept && (req_tuser == spq_pkg::FUNC_INSERT) && !is_full_now;
      cmd.remove = accept && (req_tuser == spq_pkg::FUNC_REMOVE) && !is_empty_now;
      refused    = (req_tuser == spq_pkg::FUNC_INSERT) ? is_full_now : is_empty_now;
   end

   generate
      for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
         spq_pkg::entry_type left_entry;
         spq_pkg::entry_type right_entry;
         logic               left_shift;
         if (i == 0) begin : g_first
            assign left_entry = '0;
            assign left_shift = 1'b0;
         end else begin : g_mid
            assign left_entry = cells[i-1];
            assign left_shift = shifts[i-1];
         end
         if (i == CAPACITY-1) begin : g_last
            assign right_entry = '0;
         end else begin : g_inner
            assign right_entry = cells[i+1];
         end
         spq_cell #(
            .CAPACITY (CAPACITY),
            .INDEX    (i)
         ) u_cell (
            .clock       (clock),
            .cmd         (cmd),
            .count       (count_ff),
            .left_entry  (left_entry),
            .left_shift  (left_shift),
            .right_entry (right_entry),
            .entry       (cells[i]),
            .shift_out   (shifts[i])
         );
      end
   endgenerate

   assign head = cells[0];

   always_comb begin
      count_in = count_ff;
      if (cmd.insert) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.remove) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_comb begin
      rsp_data_in        = '0;
      rsp_data_in[15:0]  = cmd.remove ? head.score : '0;
      rsp_data_in[31:16] = cmd.remove ? head.arrival : '0;
      rsp_data_in[32]    = cmd.remove;
      rsp_data_in[33]    = refused;
      rsp_data_in[38:34] = spq_pkg::COUNT_OUT_WIDTH'(count_in);
      rsp_data_in[39]    = (count_in == '0);
      rsp_data_in[40]    = (count_in == CountWidth'(CAPACITY));
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // count stays within the store
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountWidth'(CAPACITY))
      else $error("queue count beyond capacity");

   // head and second entry stay in service order
   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (count_ff >= CountWidth'(2)) |-> !spq_pkg::goes_before(cells[1], cells[0]))
      else $error("queue head out of order");

   // a successful insert grows the count by one
   a_insert_count: assert property (@(posedge clock) disable iff (reset)
      cmd.insert |=> (count_ff == $past(count_ff) + 1'b1))
      else $error("insert did not grow count");

   // a result never reports both an entry and an error
   a_rsp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[32] && rsp_tdata[33]))
      else $error("result flags entry and error together");

endmodule
`default_nettype wire

@@ bench/sorted_priority_queue_tb.sv @@
// self-checking bench for the sorted priority queue with a sorted-array predictor
`timescale 1ns / 1ps
module sorted_priority_queue_tb;

   localparam int DEPTH       = spq_pkg::CAPACITY_DEFAULT;
   localparam int CYCLE_LIMIT = 400000;

   // one result as the rsp_ channel packs it, lowest field last
   typedef struct packed {
      logic [6:0]                          pad;
      logic                                is_full;
      logic                                is_empty;
      logic [spq_pkg::COUNT_OUT_WIDTH-1:0] entry_count;
      logic                                op_error;
      logic                                out_valid;
      logic [spq_pkg::ARRIVAL_WIDTH-1:0]   out_arrival;
      logic [spq_pkg::SCORE_WIDTH-1:0]     out_score;
   } queue_rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic        req_tuser = spq_pkg::FUNC_INSERT;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;

   int send_idle_pct = 37;
   int recv_idle_pct = 85;
   int fail_count    = 0;
   int cycle_count   = 0;

   // predicted queue contents, position 0 is the head
   spq_pkg::entry_type held [DEPTH];
   int                 held_count = 0;
   queue_rsp_type      pending_rsp [$];

   sorted_priority_queue #(.CAPACITY(DEPTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // higher score first, then earlier arrival; equal keys keep insert order
   function automatic logic outranks(input spq_pkg::entry_type a,
                                     input spq_pkg::entry_type b);
      if (a.score != b.score) begin
         return a.score > b.score;
      end
      return a.arrival < b.arrival;
   endfunction

   function automatic queue_rsp_type apply_queue_op(input logic func,
                                                    input spq_pkg::entry_type e);
      queue_rsp_type r;
      int            pos;
      r = '0;
      if (func == spq_pkg::FUNC_INSERT) begin
         if (held_count >= DEPTH) begin
            r.op_error = 1'b1;
         end else begin
            pos = held_count;
            while (pos > 0 && outranks(e, held[pos-1])) begin
               held[pos] = held[pos-1];
               pos--;
            end
            held[pos] = e;
            held_count++;
         end
      end else begin
         if (held_count == 0) begin
            r.op_error = 1'b1;
         end else begin
            r.out_score   = held[0].score;
            r.out_arrival = held[0].arrival;
            r.out_valid   = 1'b1;
            for (pos = 1; pos < held_count; pos++) begin
               held[pos-1] = held[pos];
            end
            held_count--;
         end
      end
      r.entry_count = held_count[spq_pkg::COUNT_OUT_WIDTH-1:0];
      r.is_empty    = (held_count == 0);
      r.is_full     = (held_count >= DEPTH);
      return r;
   endfunction

   // item is taken at the first edge with tready high; tvalid drops only for an idle gap
   task automatic send_op(input logic func, input spq_pkg::entry_type e);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {e.arrival, e.score};
      do @(posedge clock); while (!req_tready);
      pending_rsp.push_back(apply_queue_op(func, e));
   endtask

   function automatic void check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin : check_rsp
      queue_rsp_type want;
      queue_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata;
         if (pending_rsp.size() == 0) begin
            $error("result with no item outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("out_score",   want.out_score,   got.out_score);
            check_field("out_arrival", want.out_arrival, got.out_arrival);
            check_field("out_valid",   want.out_valid,   got.out_valid);
            check_field("op_error",    want.op_error,    got.op_error);
            check_field("entry_count", want.entry_count, got.entry_count);
            check_field("is_empty",    want.is_empty,    got.is_empty);
            check_field("is_full",     want.is_full,     got.is_full);
            check_field("pad",         want.pad,         got.pad);
         end
      end
   end

   // mix of full-range values and a few crowded ones so ties happen often
   function automatic logic [15:0] pick_key();
      case ($urandom_range(3))
         0: return 16'($urandom_range(16'hFFFF));
         1: return 16'($urandom_range(3));
         2: return 16'hFFFF - 16'($urandom_range(3));
         default: return 16'h8000 + 16'($urandom_range(1));
      endcase
   endfunction

   task automatic test_remove_on_empty();
      send_op(spq_pkg::FUNC_REMOVE, '{score: 16'hFFFF, arrival: 16'hFFFF});
   endtask

   // extremes, equal scores with different arrivals and exact duplicates
   task automatic test_fill_to_full();
      logic [31:0] fill_set [16] = '{
         32'hFFFF_0000, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_0000,
         32'h8000_1234, 32'h8000_1233, 32'h8000_1234, 32'h8000_1233,
         32'h0001_0001, 32'hFFFE_0007, 32'hFFFE_0006, 32'hFFFE_0008,
         32'h7FFF_5555, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_0000};
      for (int i = 0; i < 16; i++) begin
         send_op(spq_pkg::FUNC_INSERT, fill_set[i]);
      end
   endtask

   task automatic test_insert_on_full();
      send_op(spq_pkg::FUNC_INSERT, '{score: 16'hFFFF, arrival: 16'h0000});
   endtask

   task automatic test_remove_head();
      for (int i = 0; i < 4; i++) begin
         send_op(spq_pkg::FUNC_REMOVE, '0);
      end
   endtask

   // runs lean toward insert or remove so the queue swings between full and empty
   task automatic test_random_mix(input int n_items);
      int                 insert_pct;
      int                 run_left;
      spq_pkg::entry_type e;
      run_left = 0;
      insert_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(4, 40);
            case ($urandom_range(2))
               0: insert_pct = 20;
               1: insert_pct = 50;
               default: insert_pct = 80;
            endcase
         end
         run_left--;
         e.score   = pick_key();
         e.arrival = pick_key();
         send_op(($urandom_range(99) < insert_pct) ? spq_pkg::FUNC_INSERT
                                                   : spq_pkg::FUNC_REMOVE, e);
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_remove_on_empty();
      test_fill_to_full();
      test_insert_on_full();
      test_remove_head();
      test_random_mix(600);
      send_idle_pct = 85;
      recv_idle_pct = 37;
      test_random_mix(600);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_mix(600);
      req_tvalid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sorted_priority_queue.f @@
design/spq_pkg.sv
design/spq_cell.sv
design/sorted_priority_queue.sv
bench/sorted_priority_queue_tb.sv
